@@ src/swrl_pkg.sv @@
package swrl_pkg;

  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned APB_W    = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [TIME_W-1:0] WINDOW_MIN_MS   = 32'd10;
  localparam logic [TIME_W-1:0] WINDOW_RESET_MS = 32'd1000;

  localparam logic REG_REQUEST_LIMIT = 1'b0;
  localparam logic REG_WINDOW_MS     = 1'b1;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_CLEAR   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic               granted;
    logic [TIME_W-1:0]  retry_after_ms;
    logic [LIMIT_W-1:0] held_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CHECK = 2'b10
  } state_t;

endpackage

@@ src/sliding_window_rate_limiter_core.sv @@
// a clear, or a request with limiting disabled, gives its result in the cycle after start
// a request drops expired stamps in the check state (one per cycle, set by the single read port
// of the stamp memory), then registers its result; busy is high until the result is out
// a new transaction may start in the cycle that its predecessor's result is shown
// reset clears pointers and stamp count, sets config registers; stamp memory keeps its contents
// the receiver cannot stall: done marks each result for exactly one cycle
module sliding_window_rate_limiter_core #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  swrl_pkg::item_t                item,
  output logic                           done,
  output swrl_pkg::result_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swrl_pkg::ADDR_W-1:0]    paddr,
  input  logic [swrl_pkg::APB_W-1:0]     pwdata,
  output logic [swrl_pkg::APB_W-1:0]     prdata,
  output logic                           pready
);
  import swrl_pkg::*;

  localparam int unsigned PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(HISTORY_DEPTH);

  logic [TIME_W-1:0] mem [HISTORY_DEPTH];
  logic [TIME_W-1:0] rd_data;
  logic [PTR_W-1:0]  rd_addr;
  logic              mem_we;

  state_t             state;
  logic [PTR_W-1:0]   oldest;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   held;
  logic [TIME_W-1:0]  now_q;
  logic [LIMIT_W-1:0] request_limit;
  logic [TIME_W-1:0]  window_ms;

  logic [PTR_W-1:0]  oldest_inc;
  logic [PTR_W-1:0]  wr_inc;
  logic [TIME_W-1:0] age;
  logic              pop;
  logic [LIM_W-1:0]  limit_req;
  logic [LIM_W-1:0]  limit_eff;
  logic              at_limit;
  logic [CNT_W-1:0]  held_inc;
  logic [31:0]       held_wide;
  logic [31:0]       held_inc_wide;
  logic              accept;
  logic              cfg_write;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    oldest_inc    = (oldest == PTR_LAST) ? '0 : PTR_W'(oldest + 1'b1);
    wr_inc        = (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
    age           = now_q - rd_data;
    pop           = (held != '0) && (age > window_ms);
    limit_req     = LIM_W'(request_limit);
    limit_eff     = (limit_req > DEPTH_LIM) ? DEPTH_LIM : limit_req;
    at_limit      = (LIM_W'(held) >= limit_eff);
    held_inc      = CNT_W'(held + 1'b1);
    held_wide     = 32'(held);
    held_inc_wide = 32'(held_inc);
    mem_we        = (state == ST_CHECK) && !pop && !at_limit;
    rd_addr       = ((state == ST_CHECK) && pop) ? oldest_inc : oldest;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr] <= now_q;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_limit <= '0;
      window_ms     <= WINDOW_RESET_MS;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_REQUEST_LIMIT: request_limit <= pwdata[LIMIT_W-1:0];
        REG_WINDOW_MS:     window_ms <= (pwdata < WINDOW_MIN_MS) ? WINDOW_MIN_MS : pwdata;
        default:           request_limit <= request_limit;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_REQUEST_LIMIT: prdata = APB_W'(request_limit);
      REG_WINDOW_MS:     prdata = window_ms;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      oldest <= '0;
      wr_ptr <= '0;
      held   <= '0;
      done   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          done <= accept && ((item.kind == KIND_CLEAR) || (request_limit == '0));
          if (accept) begin
            now_q <= item.now_ms;
            if (item.kind == KIND_CLEAR) begin
              oldest <= '0;
              wr_ptr <= '0;
              held   <= '0;
              result <= '{granted: 1'b0, retry_after_ms: '0, held_count: '0};
            end else if (request_limit == '0) begin
              result <= '{granted: 1'b1, retry_after_ms: '0, held_count: '0};
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          done <= !pop;
          if (pop) begin
            oldest <= oldest_inc;
            held   <= CNT_W'(held - 1'b1);
          end else begin
            state <= ST_IDLE;
            if (at_limit) begin
              result <= '{granted: 1'b0, retry_after_ms: window_ms - age,
                          held_count: held_wide[LIMIT_W-1:0]};
            end else begin
              wr_ptr <= wr_inc;
              held   <= held_inc;
              result <= '{granted: 1'b1, retry_after_ms: '0,
                          held_count: held_inc_wide[LIMIT_W-1:0]};
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule
